FILE: hdl/lac_pkg.sv
// Shared constants and types for the layer alpha compositor.
`default_nettype none

package lac_pkg;

    // Number of layers that take part in compositing
    localparam int LacLayers = 4;

    // Fixed field widths
    localparam int ChanW    = 8;
    localparam int IdxW     = 2;
    localparam int OpW      = 7;
    localparam int VisW     = 4;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 7;

    // Weight and divider widths
    localparam int WeightW  = 23;
    localparam int SumW     = 24;
    localparam int NumW     = 32;
    localparam int DivW     = 33;
    localparam int QuotBits = 9;
    localparam int MulW     = ChanW + WeightW;

    // Arithmetic constants
    localparam int AlphaScale = 25500;
    localparam int Full       = 255;

    // Configuration register indexes
    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    localparam cfg_idx_t RegOpacity0 = 3'd0;
    localparam cfg_idx_t RegOpacity1 = 3'd1;
    localparam cfg_idx_t RegOpacity2 = 3'd2;
    localparam cfg_idx_t RegOpacity3 = 3'd3;
    localparam cfg_idx_t RegVisible  = 3'd4;

    // Reset values of the registers
    localparam logic [OpW-1:0]  OpacityReset = 7'd100;
    localparam logic [VisW-1:0] VisibleReset = 4'hF;

    typedef logic [ChanW-1:0] chan_t;

endpackage : lac_pkg

`default_nettype wire

FILE: hdl/layer_alpha_compositor_unit.sv
// Layer alpha compositor: folds layer pixels into an RGBA accumulator.
// One item at a time: a visible item with a nonzero weight sum runs the weight steps, then
// each colour (multiply twice, load, divide) and alpha (load, divide) on the shared 9-step
// divider, then finish; a zero weight sum skips to finish, an invisible layer goes there too.
// The finish step holds while an earlier composite still waits on m_tready.
// Reset (rst_n low, asynchronous) clears the accumulator, opacities 100, all layers visible.
`default_nettype none

module layer_alpha_compositor_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24], layer_index[33:32], zeros
    input  wire logic [39:0]                   s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // m_tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output      logic [31:0]                   m_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [lac_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [lac_pkg::CfgDataW-1:0]  cfg_data
);

    import lac_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_W0,
        ST_T,
        ST_W1,
        ST_CHK,
        ST_MUL0,
        ST_MUL1,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    localparam int CntW = $clog2(QuotBits);
    localparam logic [CntW-1:0] CntLast = CntW'(QuotBits - 1);
    localparam logic [DivW-1:0] AlphaDivShifted = DivW'((2 * AlphaScale) << (QuotBits - 1));
    localparam logic [1:0] ChAlpha = 2'd3;

    state_t                 state_reg, state_next;
    chan_t                  acc_reg [4];
    chan_t                  acc_next [4];
    chan_t                  pix_reg [4];
    chan_t                  pix_next [4];
    logic [IdxW-1:0]        idx_reg, idx_next;
    logic                   last_reg, last_next;
    logic                   vis_item_reg, vis_item_next;
    logic [OpW-1:0]         op_reg [4];
    logic [OpW-1:0]         op_next [4];
    logic [VisW-1:0]        vis_reg, vis_next;
    logic [WeightW-1:0]     w0_reg, w0_next;
    logic [WeightW-1:0]     w1_reg, w1_next;
    logic [SumW-1:0]        sum_reg, sum_next;
    logic [NumW-1:0]        num_reg, num_next;
    logic [DivW-1:0]        rem_reg, rem_next;
    logic [DivW-1:0]        dsh_reg, dsh_next;
    logic [QuotBits-1:0]    quot_reg, quot_next;
    logic [CntW-1:0]        cnt_reg, cnt_next;
    logic [1:0]             ch_reg, ch_next;
    logic [31:0]            out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    chan_t                  mul_a;
    logic [WeightW-1:0]     mul_b;
    logic [MulW-1:0]        mul_p;
    logic [SumW-1:0]        sum_w;
    logic                   div_ge;
    logic [QuotBits-1:0]    quot_step;
    chan_t                  quot_sat;
    logic                   in_take;
    logic [IdxW-1:0]        in_idx;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = out_reg;
    assign m_tvalid  = out_valid_reg;

    assign in_take = s_tvalid && s_tready;
    assign in_idx  = s_tdata[33:32];

    // Select the operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_W0:
            begin
                mul_a = acc_reg[ChAlpha];
                mul_b = WeightW'(AlphaScale);
            end
            ST_T:
            begin
                mul_a = ChanW'(Full) - acc_reg[ChAlpha];
                mul_b = WeightW'(op_reg[idx_reg]);
            end
            ST_W1:
            begin
                mul_a = pix_reg[ChAlpha];
                mul_b = w1_reg;
            end
            ST_MUL0:
            begin
                mul_a = acc_reg[ch_reg];
                mul_b = w0_reg;
            end
            ST_MUL1:
            begin
                mul_a = pix_reg[ch_reg];
                mul_b = w1_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MulW'(mul_a) * MulW'(mul_b);
    assign sum_w = SumW'(w0_reg) + SumW'(w1_reg);

    // One restoring divider step and the saturated quotient
    assign div_ge    = (rem_reg >= dsh_reg);
    assign quot_step = {quot_reg[QuotBits-2:0], div_ge};
    assign quot_sat  = quot_step[QuotBits-1] ? ChanW'(Full) : quot_step[ChanW-1:0];

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        pix_next       = pix_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        vis_item_next  = vis_item_reg;
        op_next        = op_reg;
        vis_next       = vis_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // Drop the result once the sink has taken it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Apply configuration writes; unknown indexes are ignored
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                RegOpacity0: op_next[0] = cfg_data[OpW-1:0];
                RegOpacity1: op_next[1] = cfg_data[OpW-1:0];
                RegOpacity2: op_next[2] = cfg_data[OpW-1:0];
                RegOpacity3: op_next[3] = cfg_data[OpW-1:0];
                RegVisible:  vis_next   = cfg_data[VisW-1:0];
                default:     vis_next   = vis_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    pix_next[0]   = s_tdata[7:0];
                    pix_next[1]   = s_tdata[15:8];
                    pix_next[2]   = s_tdata[23:16];
                    pix_next[3]   = s_tdata[31:24];
                    idx_next      = in_idx;
                    last_next     = s_tlast;
                    vis_item_next = (int'(in_idx) < LacLayers) && vis_reg[in_idx];
                    state_next    = ((int'(in_idx) < LacLayers) && vis_reg[in_idx]) ?
                                    ST_W0 : ST_FIN;
                end
            end
            ST_W0:
            begin
                w0_next    = mul_p[WeightW-1:0];
                state_next = ST_T;
            end
            ST_T:
            begin
                w1_next    = mul_p[WeightW-1:0];
                state_next = ST_W1;
            end
            ST_W1:
            begin
                w1_next    = mul_p[WeightW-1:0];
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // Leave the accumulator alone when both weights vanish
                sum_next   = sum_w;
                ch_next    = '0;
                state_next = (sum_w == '0) ? ST_FIN : ST_MUL0;
            end
            ST_MUL0:
            begin
                num_next   = NumW'(mul_p);
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                num_next   = num_reg + NumW'(mul_p);
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Round half up: (2n + d) / (2d)
                if (ch_reg == ChAlpha)
                begin
                    rem_next = DivW'({sum_reg, 1'b0}) + DivW'(AlphaScale);
                    dsh_next = AlphaDivShifted;
                end
                else
                begin
                    rem_next = DivW'({num_reg, 1'b0}) + DivW'(sum_reg);
                    dsh_next = DivW'({sum_reg, 1'b0}) << (QuotBits - 1);
                end
                quot_next  = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = div_ge ? (rem_reg - dsh_reg) : rem_reg;
                dsh_next  = dsh_reg >> 1;
                quot_next = quot_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CntLast)
                begin
                    acc_next[ch_reg] = quot_sat;
                    ch_next          = ch_reg + 1'b1;
                    if (ch_reg == ChAlpha)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (ch_reg + 1'b1 == ChAlpha)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_MUL0;
                    end
                end
            end
            ST_FIN:
            begin
                // Emit the composite on the last layer, holding while the result is full
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_next       = {acc_next[3], acc_next[2], acc_next[1], acc_next[0]};
                    out_valid_next = 1'b1;
                    for (int i = 0; i < 4; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, datapath and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 4; i++)
            begin
                acc_reg[i] <= '0;
                pix_reg[i] <= '0;
                op_reg[i]  <= OpacityReset;
            end
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            vis_item_reg  <= 1'b0;
            vis_reg       <= VisibleReset;
            w0_reg        <= '0;
            w1_reg        <= '0;
            sum_reg       <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            dsh_reg       <= '0;
            quot_reg      <= '0;
            cnt_reg       <= '0;
            ch_reg        <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pix_reg       <= pix_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            vis_item_reg  <= vis_item_next;
            vis_reg       <= vis_next;
            w0_reg        <= w0_next;
            w1_reg        <= w1_next;
            sum_reg       <= sum_next;
            num_reg       <= num_next;
            rem_reg       <= rem_next;
            dsh_reg       <= dsh_next;
            quot_reg      <= quot_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // The sequencer is not ready in the cycle after an input transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // The divider never runs past its last quotient bit
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CntLast))
        else $error("divider step count overrun");

    // The shifted divisor is never zero while dividing
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dsh_reg != '0))
        else $error("divide by zero weight sum");

    // Only a visible item reaches the weight stage
    a_weight_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W0) |-> vis_item_reg)
        else $error("invisible layer composited");
`endif

endmodule : layer_alpha_compositor_unit

`default_nettype wire

FILE: dv/layer_alpha_compositor_unit_tb.sv
// Self-checking testbench for the layer alpha compositor: stream stimulus and over-rule prediction.
`default_nettype none

import lac_pkg::*;

// One composite pixel, packed as it travels on m_tdata (red in the lowest byte)
typedef struct packed {
    chan_t alpha;
    chan_t blue;
    chan_t green;
    chan_t red;
} rgba_t;

// Running over-rule composite of one pixel position and the composites still owed by the block
class over_composite_board;
    rgba_t           acc;
    logic [OpW-1:0]  opacity [LacLayers];
    logic [VisW-1:0] visible;
    rgba_t           owed_composites [$];
    int              errors;

    function new();
        for (int i = 0; i < LacLayers; i++)
            opacity[i] = OpacityReset;
        visible = VisibleReset;
        acc     = '0;
        errors  = 0;
    endfunction

    // Print one mismatch line and count it
    function void report(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endfunction

    // Mirror a register transfer; indexes past the visible mask are dropped
    function void write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] data);
        case (idx)
            RegOpacity0: opacity[0] = data;
            RegOpacity1: opacity[1] = data;
            RegOpacity2: opacity[2] = data;
            RegOpacity3: opacity[3] = data;
            RegVisible:  visible    = data[VisW-1:0];
            default: ;
        endcase
    endfunction

    // Quotient rounded half up
    function longint unsigned half_up(longint unsigned num, longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function chan_t blend(chan_t c0, chan_t c1, longint unsigned w0, longint unsigned w1);
        longint unsigned q;
        q = half_up(64'(c0) * w0 + 64'(c1) * w1, w0 + w1);
        return (q > Full) ? chan_t'(Full) : chan_t'(q);
    endfunction

    // Fold one accepted layer transfer into the composite; owe a result on the last layer
    function void fold_layer(logic [39:0] tdata, logic last);
        chan_t           r;
        chan_t           g;
        chan_t           b;
        chan_t           a;
        logic [IdxW-1:0] layer;
        longint unsigned w0;
        longint unsigned w1;
        longint unsigned na;
        r     = tdata[7:0];
        g     = tdata[15:8];
        b     = tdata[23:16];
        a     = tdata[31:24];
        layer = tdata[33:32];
        if (int'(layer) < LacLayers && visible[layer]) begin
            w0 = 64'(acc.alpha) * 64'(AlphaScale);
            w1 = 64'(Full - acc.alpha) * 64'(opacity[layer]) * 64'(a);
            // Leave the composite untouched when both weights vanish
            if (w0 + w1 != 0) begin
                na        = half_up(w0 + w1, AlphaScale);
                acc.red   = blend(acc.red, r, w0, w1);
                acc.green = blend(acc.green, g, w0, w1);
                acc.blue  = blend(acc.blue, b, w0, w1);
                acc.alpha = (na > Full) ? chan_t'(Full) : chan_t'(na);
            end
        end
        if (last) begin
            owed_composites = {owed_composites, acc};
            acc = '0;
        end
    endfunction

    function void compare_chan(string name, chan_t got, chan_t want);
        if (got !== want)
            report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    endfunction

    // Check one result transfer against the oldest owed composite
    function void check_result(logic [31:0] tdata);
        rgba_t got;
        rgba_t want;
        got = tdata;
        if (owed_composites.size() == 0) begin
            report($sformatf("unexpected composite 0x%08h", tdata));
            return;
        end
        want = owed_composites.pop_front();
        compare_chan("out_red", got.red, want.red);
        compare_chan("out_green", got.green, want.green);
        compare_chan("out_blue", got.blue, want.blue);
        compare_chan("out_alpha", got.alpha, want.alpha);
    endfunction
endclass

module layer_alpha_compositor_unit_tb;

    localparam int SettleCycles  = 64;
    localparam int WatchdogLimit = 4000;
    localparam int PhaseCount    = 8;
    localparam int PhaseItems    = 180;

    logic                clk;
    logic                rst_n;
    logic [39:0]         s_tdata;
    logic                s_tlast;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                cfg_valid;
    logic                cfg_ready;
    cfg_idx_t            cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    over_composite_board board;
    int                  burst_left;
    int                  layers_sent;
    int                  idle_cycles;

    layer_alpha_compositor_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: switch between always ready, coin-flip and long stalls
    initial
    begin
        int rx_mode;
        int rx_left;
        rx_mode  = 0;
        rx_left  = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready = 1'b1;
                1:       m_tready = 1'($urandom_range(0, 1));
                default: m_tready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Observe every transfer at the rising edge and feed the board
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.fold_layer(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // Watchdog: give up after a long stretch with no transfer at all
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one layer transfer; open a new burst after a random gap when the last one ran out
    task automatic send_layer(chan_t r, chan_t g, chan_t b, chan_t a,
                              logic [IdxW-1:0] layer, logic last);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
        end
        s_tdata  = {6'b0, layer, a, b, g, r};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        burst_left--;
        layers_sent++;
    endtask

    // Hold the sender until every owed composite has come and the block has gone quiet
    task automatic drain_block();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (board.owed_composites.size() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    function automatic chan_t pick_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic chan_t pick_alpha();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly whole pixels walked top layer first; the rest stray layers with random last flags
    task automatic send_random_pixel();
        int depth;
        if ($urandom_range(0, 6) == 0)
            send_layer(pick_chan(), pick_chan(), pick_chan(), pick_alpha(),
                       IdxW'($urandom_range(0, LacLayers - 1)), ($urandom_range(0, 2) == 0));
        else
        begin
            depth = $urandom_range(1, LacLayers);
            for (int k = 0; k < depth; k++)
                send_layer(pick_chan(), pick_chan(), pick_chan(), pick_alpha(),
                           IdxW'(k), (k == depth - 1));
        end
    endtask

    // Set all registers for one phase: defaults, maxima, zeros and random mixes
    task automatic configure_phase(int phase);
        logic [CfgDataW-1:0] op;
        logic [CfgDataW-1:0] mask;
        cfg_idx_t            spare;
        drain_block();
        for (int i = 0; i < LacLayers; i++)
        begin
            case (phase)
                0:       op = OpacityReset;
                1:       op = 7'd127;
                2:       op = $urandom_range(0, 1) ? 7'd0 : OpacityReset;
                default: op = ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom_range(0, 127))
                                                          : CfgDataW'($urandom_range(20, 100));
            endcase
            write_reg(cfg_idx_t'(RegOpacity0 + i), op);
        end
        mask = CfgDataW'($urandom_range(0, 127));
        if (phase < 2)
            mask[VisW-1:0] = VisibleReset;
        else if (phase == 3)
            mask[VisW-1:0] = '0;
        write_reg(RegVisible, mask);
        spare = cfg_idx_t'($urandom_range(RegVisible + 1, (1 << CfgIdxW) - 1));
        write_reg(spare, CfgDataW'($urandom_range(0, 127)));
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int phase_start;
        board       = new();
        rst_n       = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tvalid    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = RegOpacity0;
        cfg_data    = '0;
        burst_left  = 0;
        layers_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: opaque white, zero weight sum, four-layer stack, covered and reversed
        send_layer(8'd255, 8'd255, 8'd255, 8'd255, 2'd0, 1'b1);
        send_layer(8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 1'b1);
        send_layer(8'd200, 8'd10, 8'd30, 8'd128, 2'd0, 1'b0);
        send_layer(8'd0, 8'd255, 8'd0, 8'd255, 2'd1, 1'b0);
        send_layer(8'd7, 8'd7, 8'd7, 8'd0, 2'd2, 1'b0);
        send_layer(8'd255, 8'd0, 8'd255, 8'd255, 2'd3, 1'b1);
        send_layer(8'd0, 8'd0, 8'd0, 8'd255, 2'd0, 1'b0);
        send_layer(8'd255, 8'd255, 8'd255, 8'd255, 2'd1, 1'b1);
        send_layer(8'd90, 8'd90, 8'd90, 8'd0, 2'd0, 1'b0);
        send_layer(8'd12, 8'd34, 8'd56, 8'd1, 2'd1, 1'b1);
        send_layer(8'd128, 8'd64, 8'd32, 8'd77, 2'd3, 1'b0);
        send_layer(8'd1, 8'd2, 8'd4, 8'd200, 2'd0, 1'b1);

        // Opacity above 100, opacity zero, hidden layers, mask upper bits and spare indexes
        drain_block();
        write_reg(RegOpacity0, 7'd127);
        write_reg(RegOpacity1, 7'd0);
        write_reg(RegOpacity2, 7'd50);
        write_reg(RegOpacity3, 7'd101);
        write_reg(RegVisible, 7'b1110101);
        write_reg(cfg_idx_t'(RegVisible + 1), 7'h7F);
        write_reg(cfg_idx_t'(RegVisible + 2), 7'h00);
        write_reg(cfg_idx_t'(RegVisible + 3), 7'h55);
        cfg_valid = 1'b0;
        send_layer(8'd255, 8'd128, 8'd1, 8'd255, 2'd0, 1'b0);
        send_layer(8'd9, 8'd99, 8'd199, 8'd255, 2'd2, 1'b1);
        send_layer(8'd1, 8'd2, 8'd3, 8'd255, 2'd1, 1'b1);
        send_layer(8'd10, 8'd20, 8'd30, 8'd200, 2'd0, 1'b0);
        send_layer(8'd250, 8'd250, 8'd250, 8'd255, 2'd3, 1'b1);
        drain_block();
        write_reg(RegVisible, 7'b0001111);
        cfg_valid = 1'b0;
        send_layer(8'd50, 8'd60, 8'd70, 8'd255, 2'd1, 1'b1);
        send_layer(8'd33, 8'd66, 8'd99, 8'd255, 2'd3, 1'b1);
        send_layer(8'd0, 8'd0, 8'd0, 8'd0, 2'd2, 1'b0);
        send_layer(8'd255, 8'd255, 8'd255, 8'd255, 2'd1, 1'b0);
        send_layer(8'd100, 8'd150, 8'd200, 8'd255, 2'd3, 1'b1);

        // Random phases, each under its own register settings
        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            configure_phase(phase);
            phase_start = layers_sent;
            while (layers_sent - phase_start < PhaseItems)
            begin
                send_random_pixel();
                if (phase == 4 && layers_sent - phase_start == PhaseItems / 2)
                    drain_block();
            end
        end

        // Wait for the last composites, then let the block go quiet
        s_tvalid = 1'b0;
        while (board.owed_composites.size() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
        if (board.owed_composites.size() != 0)
            board.report($sformatf("%0d composites never arrived",
                                   board.owed_composites.size()));
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
